/* rtl/scaled_distance_3d_assert.svh */
// Assertion macros for the scaled_distance_3d checker.
// Depends on nothing; included by the checker file only.
`ifndef SCALED_DISTANCE_3D_ASSERT_SVH
`define SCALED_DISTANCE_3D_ASSERT_SVH

// Checked at every clock edge except while reset is high
`define SD3_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every clock edge, reset included
`define SD3_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/sd3_pkg.sv */
// Shared widths, sequencer state type and helper function for scaled_distance_3d.
// No dependencies.
package sd3_pkg;

  localparam int COORD_W    = 32;               // input coordinate width
  localparam int DIFF_W     = COORD_W + 1;      // exact difference width
  localparam int DIG_W      = 16;               // scaled difference width
  localparam int SUM_W      = 32;               // sum of three squares
  localparam int ROOT_W     = SUM_W / 2;        // floor root width
  localparam int STEP_W     = 5;                // shift count width
  localparam int DIST_W     = 33;               // output distance width
  localparam int ROOT_CNT_W = $clog2(ROOT_W);   // root iteration counter

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCALE,
    ST_SUMSQ,
    ST_ROOT
  } state_t;

  // True when a difference already fits a signed 16-bit value
  function automatic logic fits_dig(input logic [DIFF_W-1:0] v);
    logic [DIFF_W-DIG_W:0] top;
    top      = v[DIFF_W-1:DIG_W-1];
    fits_dig = (top == '0) || (top == '1);
  endfunction

endpackage

/* rtl/sd3_prescale.sv */
// Difference and pre-scale unit: forms the exact differences, then shifts
// them right one bit per cycle until all fit 16 bits. Uses sd3_pkg.
module sd3_prescale (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  load,
  input  logic signed [sd3_pkg::COORD_W-1:0]   item_x,
  input  logic signed [sd3_pkg::COORD_W-1:0]   item_y,
  input  logic signed [sd3_pkg::COORD_W-1:0]   item_z,
  input  logic signed [sd3_pkg::COORD_W-1:0]   target_x,
  input  logic signed [sd3_pkg::COORD_W-1:0]   target_y,
  input  logic signed [sd3_pkg::COORD_W-1:0]   target_z,
  output logic signed [sd3_pkg::DIG_W-1:0]     dx,
  output logic signed [sd3_pkg::DIG_W-1:0]     dy,
  output logic signed [sd3_pkg::DIG_W-1:0]     dz,
  output logic        [sd3_pkg::STEP_W-1:0]    steps,
  output logic                                  done
);

  logic                                active;
  logic signed [sd3_pkg::DIFF_W-1:0]   diff_x, diff_y, diff_z;
  logic                                all_fit;

  assign all_fit = sd3_pkg::fits_dig(diff_x) && sd3_pkg::fits_dig(diff_y) &&
                   sd3_pkg::fits_dig(diff_z);

  // Busy flag: set on load, cleared once all three differences fit
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (load) begin
      active <= 1'b1;
    end else if (active && all_fit) begin
      active <= 1'b0;
    end
  end

  // Difference shift registers and step counter
  always_ff @(posedge clk) begin
    if (load) begin
      diff_x <= {item_x[sd3_pkg::COORD_W-1], item_x} -
                {target_x[sd3_pkg::COORD_W-1], target_x};
      diff_y <= {item_y[sd3_pkg::COORD_W-1], item_y} -
                {target_y[sd3_pkg::COORD_W-1], target_y};
      diff_z <= {item_z[sd3_pkg::COORD_W-1], item_z} -
                {target_z[sd3_pkg::COORD_W-1], target_z};
      steps  <= '0;
    end else if (active && !all_fit) begin
      diff_x <= diff_x >>> 1;
      diff_y <= diff_y >>> 1;
      diff_z <= diff_z >>> 1;
      steps  <= steps + 1'b1;
    end
  end

  assign done = active && all_fit;
  assign dx   = diff_x[sd3_pkg::DIG_W-1:0];
  assign dy   = diff_y[sd3_pkg::DIG_W-1:0];
  assign dz   = diff_z[sd3_pkg::DIG_W-1:0];

endmodule

/* rtl/sd3_sumsq.sv */
// Sum of squares: one shared 16x16 multiplier, one difference per cycle,
// accumulated in turn. Uses sd3_pkg.
module sd3_sumsq (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [sd3_pkg::DIG_W-1:0]   dx,
  input  logic signed [sd3_pkg::DIG_W-1:0]   dy,
  input  logic signed [sd3_pkg::DIG_W-1:0]   dz,
  output logic        [sd3_pkg::SUM_W-1:0]   sum,
  output logic                                done
);

  localparam logic [1:0] LAST_IDX = 2'd2;

  logic                               active;
  logic [1:0]                         idx;
  logic signed [sd3_pkg::DIG_W-1:0]   sel;
  logic signed [sd3_pkg::SUM_W-1:0]   prod;

  // Operand select
  always_comb begin
    case (idx)
      2'd0:    sel = dx;
      2'd1:    sel = dy;
      default: sel = dz;
    endcase
  end

  assign prod = sel * sel;

  // Control: multiply until the last difference, then a one-cycle done
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= active && (idx == LAST_IDX);
      if (start) begin
        active <= 1'b1;
      end else if (active && (idx == LAST_IDX)) begin
        active <= 1'b0;
      end
    end
  end

  // Accumulator and operand index
  always_ff @(posedge clk) begin
    if (start) begin
      sum <= '0;
      idx <= '0;
    end else if (active) begin
      sum <= sum + $unsigned(prod);
      idx <= idx + 1'b1;
    end
  end

endmodule

/* rtl/sd3_isqrt.sv */
// Floor integer square root, restoring digit-by-digit: two radicand bits
// and one root bit per cycle. Uses sd3_pkg.
module sd3_isqrt (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [sd3_pkg::SUM_W-1:0]      radicand,
  output logic [sd3_pkg::ROOT_W-1:0]     root,
  output logic                           done
);

  localparam int REM_W = sd3_pkg::ROOT_W + 2;
  localparam logic [sd3_pkg::ROOT_CNT_W-1:0] LAST_CNT =
    sd3_pkg::ROOT_CNT_W'(sd3_pkg::ROOT_W - 1);

  logic                               active;
  logic [sd3_pkg::ROOT_CNT_W-1:0]     cnt;
  logic [sd3_pkg::SUM_W-1:0]          rad;
  logic [REM_W-1:0]                   rem;
  logic [REM_W+1:0]                   rem_trial;
  logic [REM_W+1:0]                   trial;
  logic [REM_W+1:0]                   rem_sub;
  logic                               take;

  // One digit step: bring down two bits, try subtracting 4*root+1
  assign rem_trial = {rem, rad[sd3_pkg::SUM_W-1 -: 2]};
  assign trial     = {2'b00, root, 2'b01};
  assign take      = rem_trial >= trial;
  assign rem_sub   = rem_trial - trial;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= active && (cnt == LAST_CNT);
      if (start) begin
        active <= 1'b1;
      end else if (active && (cnt == LAST_CNT)) begin
        active <= 1'b0;
      end
    end
  end

  // Radicand shift register, partial remainder and root
  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
      cnt  <= '0;
    end else if (active) begin
      rad  <= {rad[sd3_pkg::SUM_W-3:0], 2'b00};
      rem  <= take ? rem_sub[REM_W-1:0] : rem_trial[REM_W-1:0];
      root <= {root[sd3_pkg::ROOT_W-2:0], take};
      cnt  <= cnt + 1'b1;
    end
  end

endmodule

/* rtl/scaled_distance_3d.sv */
// scaled_distance_3d: approximate 3D distance via pre-scale, sum of squares, floor root.
// Each accepted item is shifted s = shift_count (0..17) times in the one-bit-per-cycle
// pre-scale, then passes the shared multiplier, 16 root digits and the output register,
// which raises the result strobe. One item at a time; the next may be accepted in the
// strobe cycle. Synchronous reset: idle.
// Depends on sd3_pkg, sd3_prescale, sd3_sumsq, sd3_isqrt.
module scaled_distance_3d (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [sd3_pkg::COORD_W-1:0]   item_x,
  input  logic signed [sd3_pkg::COORD_W-1:0]   item_y,
  input  logic signed [sd3_pkg::COORD_W-1:0]   item_z,
  input  logic signed [sd3_pkg::COORD_W-1:0]   target_x,
  input  logic signed [sd3_pkg::COORD_W-1:0]   target_y,
  input  logic signed [sd3_pkg::COORD_W-1:0]   target_z,
  output logic                                  done,
  output logic        [sd3_pkg::DIST_W-1:0]    distance,
  output logic        [sd3_pkg::STEP_W-1:0]    shift_count
);

  sd3_pkg::state_t                     state, state_next;
  logic                                load;
  logic                                sq_start, rt_start, out_load;
  logic                                pre_done, sq_done, rt_done;
  logic signed [sd3_pkg::DIG_W-1:0]    dx, dy, dz;
  logic [sd3_pkg::STEP_W-1:0]          steps;
  logic [sd3_pkg::SUM_W-1:0]           sum;
  logic [sd3_pkg::ROOT_W-1:0]          root;

  assign load = start && !busy;

  sd3_prescale u_prescale (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .item_x   (item_x),
    .item_y   (item_y),
    .item_z   (item_z),
    .target_x (target_x),
    .target_y (target_y),
    .target_z (target_z),
    .dx       (dx),
    .dy       (dy),
    .dz       (dz),
    .steps    (steps),
    .done     (pre_done)
  );

  sd3_sumsq u_sumsq (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .dx    (dx),
    .dy    (dy),
    .dz    (dz),
    .sum   (sum),
    .done  (sq_done)
  );

  sd3_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (rt_start),
    .radicand (sum),
    .root     (root),
    .done     (rt_done)
  );

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sd3_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer next state and unit starts
  always_comb begin
    state_next = state;
    sq_start   = 1'b0;
    rt_start   = 1'b0;
    out_load   = 1'b0;
    case (state)
      sd3_pkg::ST_IDLE: begin
        if (start) begin
          state_next = sd3_pkg::ST_SCALE;
        end
      end
      sd3_pkg::ST_SCALE: begin
        if (pre_done) begin
          sq_start   = 1'b1;
          state_next = sd3_pkg::ST_SUMSQ;
        end
      end
      sd3_pkg::ST_SUMSQ: begin
        if (sq_done) begin
          rt_start   = 1'b1;
          state_next = sd3_pkg::ST_ROOT;
        end
      end
      sd3_pkg::ST_ROOT: begin
        if (rt_done) begin
          out_load   = 1'b1;
          state_next = sd3_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sd3_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state != sd3_pkg::ST_IDLE);

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= out_load;
    end
  end

  // Result payload: root scaled back up by the shift count
  always_ff @(posedge clk) begin
    if (out_load) begin
      distance    <= sd3_pkg::DIST_W'(root) << steps;
      shift_count <= steps;
    end
  end

endmodule

/* rtl/sd3_check.sv */
// Port-level checker for scaled_distance_3d, bound to the top level.
// Depends on sd3_pkg, scaled_distance_3d_assert.svh and the scaled_distance_3d ports.
`include "scaled_distance_3d_assert.svh"

module sd3_check (
  input logic                           clk,
  input logic                           rst,
  input logic                           start,
  input logic                           busy,
  input logic                           done,
  input logic [sd3_pkg::DIST_W-1:0]     distance,
  input logic [sd3_pkg::STEP_W-1:0]     shift_count
);

  localparam logic [sd3_pkg::STEP_W-1:0] MAX_STEPS = 5'd17;
  localparam logic [sd3_pkg::DIST_W-1:0] MAX_ROOT  = 33'd65535;

  // An accepted item keeps the block busy in the next cycle
  `SD3_ASSERT(a_accept_busy, (start && !busy) |=> busy, "busy did not rise after accept")

  // Results never come in consecutive cycles, and the block is free when one shows
  `SD3_ASSERT(a_done_single, done |=> !done, "result strobe held two cycles")
  `SD3_ASSERT(a_done_idle, done |-> !busy, "busy high with result strobe")

  // Shift count in range and distance is a 16-bit root scaled by it
  `SD3_ASSERT(a_result_shape,
    done |-> (shift_count <= MAX_STEPS) && ((distance >> shift_count) <= MAX_ROOT),
    "result out of range")

  // Reset leaves the block idle with no result
  `SD3_ASSERT_ALWAYS(a_reset_idle, rst |=> (!busy && !done), "not idle after reset")

endmodule

bind scaled_distance_3d sd3_check u_sd3_check (.*);

/* tb/sv/testbench.sv */
// Self-checking testbench for scaled_distance_3d: predicts every distance and shift count
// from the two points of each item and compares each result as it is strobed out.
// Depends on sd3_pkg and the scaled_distance_3d RTL.
module testbench;

  localparam int CLK_HALF    = 4;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 64;
  localparam int RANDOM_ITEMS = 540;
  localparam int CALM_ITEMS  = 80;

  typedef logic signed [sd3_pkg::COORD_W-1:0] coord_t;

  // one pair of points plus the idle time that goes before it and whether to drain first
  typedef struct {
    coord_t ix, iy, iz;
    coord_t tx, ty, tz;
    int     gap;
    bit     drain;
  } coord_pair_t;

  typedef struct {
    logic [sd3_pkg::DIST_W-1:0] distance;
    logic [sd3_pkg::STEP_W-1:0] steps;
  } dist_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  coord_t item_x = '0, item_y = '0, item_z = '0;
  coord_t target_x = '0, target_y = '0, target_z = '0;
  logic busy, done;
  logic [sd3_pkg::DIST_W-1:0] distance;
  logic [sd3_pkg::STEP_W-1:0] shift_count;

  coord_pair_t  coord_queue[$];
  dist_result_t pending_distances[$];

  logic taken = 1'b0;
  bit   holding = 1'b0;
  int   waited = 0;
  int   cycles = 0;
  int   errors = 0;
  int   n_accepted = 0;
  int   n_checked = 0;
  int   n_no_shift = 0;
  int   n_full_shift = 0;

  scaled_distance_3d u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .item_x     (item_x),
    .item_y     (item_y),
    .item_z     (item_z),
    .target_x   (target_x),
    .target_y   (target_y),
    .target_z   (target_z),
    .done       (done),
    .distance   (distance),
    .shift_count(shift_count)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Expected result: scale the exact differences into 16 bits, floor root, scale back
  function automatic dist_result_t calc_scaled_distance(input coord_pair_t c);
    longint dx, dy, dz, sum;
    logic [63:0] root, trial, wide;
    int steps;
    dist_result_t r;
    dx = longint'(c.ix) - longint'(c.tx);
    dy = longint'(c.iy) - longint'(c.ty);
    dz = longint'(c.iz) - longint'(c.tz);
    steps = 0;
    while (dx < -32768 || dx > 32767 || dy < -32768 || dy > 32767 ||
           dz < -32768 || dz > 32767) begin
      dx = dx >>> 1;
      dy = dy >>> 1;
      dz = dz >>> 1;
      steps++;
    end
    sum = dx * dx + dy * dy + dz * dz;
    root = '0;
    for (int b = 17; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= 64'(sum)) root = trial;
    end
    wide = root << steps;
    r.distance = wide[sd3_pkg::DIST_W-1:0];
    r.steps = sd3_pkg::STEP_W'(steps);
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  task automatic add_item(input coord_t ix, iy, iz, tx, ty, tz, input int gap, input bit drain);
    coord_pair_t c;
    c.ix = ix; c.iy = iy; c.iz = iz;
    c.tx = tx; c.ty = ty; c.tz = tz;
    c.gap = gap;
    c.drain = drain;
    coord_queue.push_back(c);
  endtask

  // target coordinate that lies off from base by the given offset (wraps at 32 bits)
  function automatic coord_t offset_coord(input coord_t base, input longint off);
    longint t;
    t = longint'(base) - off;
    return t[sd3_pkg::COORD_W-1:0];
  endfunction

  // random offset whose magnitude is about 2^k, near a power-of-two boundary
  function automatic longint boundary_offset();
    longint off;
    int k;
    k = $urandom_range(0, 31);
    off = (longint'(1) << k) + longint'($urandom_range(0, 2)) - 1;
    if ($urandom_range(0, 1)) off = -off;
    return off;
  endfunction

  // random signed offset of a random width
  function automatic longint width_offset();
    longint mask;
    int k;
    k = $urandom_range(1, 32);
    mask = (longint'(1) << k) - 1;
    return (longint'($urandom) & mask) - (longint'(1) << (k - 1));
  endfunction

  // Driver: presents items at the falling edge, holds each until it is taken
  always @(negedge clk) begin
    if (!rst) begin
      if (holding && taken) begin
        holding = 1'b0;
        waited = 0;
      end
      if (!holding && coord_queue.size() > 0) begin
        if (waited < coord_queue[0].gap) begin
          if (!busy) waited++;
        end else if (!coord_queue[0].drain || pending_distances.size() == 0) begin
          coord_pair_t c;
          c = coord_queue.pop_front();
          item_x   <= c.ix;
          item_y   <= c.iy;
          item_z   <= c.iz;
          target_x <= c.tx;
          target_y <= c.ty;
          target_z <= c.tz;
          holding = 1'b1;
        end
      end
      start <= holding;
    end
  end

  // Monitor: records accepted items, checks each strobed result
  always @(posedge clk) begin
    if (rst) begin
      taken <= 1'b0;
    end else begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycles, pending_distances.size());
        $display("FAILED: results differ");
        $finish;
      end else begin
        if (done) begin
          if (pending_distances.size() == 0) begin
            report_mismatch("result strobed with no item outstanding");
          end else begin
            dist_result_t e;
            e = pending_distances.pop_front();
            n_checked++;
            if (distance !== e.distance)
              report_mismatch($sformatf("distance %0d, expected %0d", distance, e.distance));
            if (shift_count !== e.steps)
              report_mismatch($sformatf("shift_count %0d, expected %0d",
                                        shift_count, e.steps));
          end
        end
        taken <= start && !busy;
        if (start && !busy) begin
          coord_pair_t c;
          dist_result_t e;
          c.ix = item_x; c.iy = item_y; c.iz = item_z;
          c.tx = target_x; c.ty = target_y; c.tz = target_z;
          c.gap = 0;
          c.drain = 1'b0;
          e = calc_scaled_distance(c);
          pending_distances.push_back(e);
          n_accepted++;
          if (e.steps == 0) n_no_shift++;
          if (e.steps == 17) n_full_shift++;
        end
      end
    end
  end

  // Stimulus: directed corners, then random pairs, then drain and report
  initial begin
    coord_t a, b, c;
    longint ox, oy, oz;
    int gap;

    // equal points, at zero and at the extremes
    add_item(0, 0, 0, 0, 0, 0, 0, 1'b0);
    add_item(32'h7FFFFFFF, 32'h80000000, 32'h12345678,
             32'h7FFFFFFF, 32'h80000000, 32'h12345678, 0, 1'b0);
    // largest positive and negative differences on every axis
    add_item(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
             32'h80000000, 32'h80000000, 32'h80000000, 0, 1'b0);
    add_item(32'h80000000, 32'h80000000, 32'h80000000,
             32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 1'b0);
    // one axis at the extreme, the others zero
    add_item(32'h7FFFFFFF, 0, 0, 32'h80000000, 0, 0, 0, 1'b0);
    add_item(0, 32'h80000000, 0, 0, 32'h7FFFFFFF, 0, 0, 1'b0);
    add_item(0, 0, 32'h7FFFFFFF, 0, 0, 32'h80000000, 0, 1'b0);
    // -1 must not shift; 16-bit range edges
    add_item(-1, -1, -1, 0, 0, 0, 0, 1'b0);
    add_item(0, 0, 0, 32768, 32768, 32768, 0, 1'b0);
    add_item(32767, 32767, 32767, 0, 0, 0, 0, 1'b0);
    add_item(32768, 0, 0, 0, 0, 0, 0, 1'b0);
    add_item(0, 0, 0, 0, 32769, 0, 0, 1'b0);
    add_item(-32768, 5, -7, 0, 0, 0, 0, 1'b0);
    add_item(65535, -65536, 65536, 0, 0, 0, 0, 1'b0);
    add_item(0, 0, -65537, 0, 0, 0, 0, 1'b0);
    add_item(3, 4, 12, 0, 0, 0, 0, 1'b0);
    add_item(-100, 200, -300, 100, -200, 300, 0, 1'b0);
    add_item(32'hFFFFFFFF, 32'h00000001, 32'hAAAAAAAA,
             32'h00000000, 32'hFFFFFFFF, 32'h55555555, 0, 1'b0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      a = $urandom; b = $urandom; c = $urandom;
      case ($urandom_range(0, 4))
        0: begin
          ox = longint'(a) - longint'(coord_t'($urandom));
          oy = longint'(b) - longint'(coord_t'($urandom));
          oz = longint'(c) - longint'(coord_t'($urandom));
        end
        1: begin
          ox = 0; oy = 0; oz = 0;
        end
        2: begin
          ox = longint'($urandom_range(0, 80000)) - 40000;
          oy = longint'($urandom_range(0, 80000)) - 40000;
          oz = longint'($urandom_range(0, 80000)) - 40000;
        end
        3: begin
          ox = boundary_offset(); oy = boundary_offset(); oz = boundary_offset();
        end
        default: begin
          ox = width_offset(); oy = width_offset(); oz = width_offset();
        end
      endcase
      gap = 0;
      if (i < RANDOM_ITEMS - CALM_ITEMS && $urandom_range(0, 99) < 35)
        gap = $urandom_range(1, 11);
      add_item(a, b, c, offset_coord(a, ox), offset_coord(b, oy), offset_coord(c, oz),
               gap, (i == 150 || i == 380));
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (coord_queue.size() > 0 || holding) @(posedge clk);
    while (pending_distances.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d items sent, %0d results checked in %0d cycles", n_accepted, n_checked,
             cycles);
    $display("%0d items needed no scaling, %0d needed the full 17 shifts",
             n_no_shift, n_full_shift);
    if (errors == 0 && pending_distances.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
